@@ rtl/rmst_pkg.sv @@
// Shared types, constants and a helper function for the range-maximum engine.
// Used by rmst_datapath, range_max_sparse_table, rmst_result_check and tb_top; depends on nothing else.
package rmst_pkg;

  localparam int IDX_W    = 10;  // index fields on the ports
  localparam int KEY_IO_W = 32;  // key fields on the ports
  localparam int LEN_W    = 11;  // active_length register
  localparam int SPAN_W   = 11;  // span of a query, up to 1024
  localparam int LOG_W    = 4;   // floor(log2) of a span

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_BUILD = 2'd1,
    OP_QUERY = 2'd2
  } opcode_e;

  // Work started by the controller in one cycle.
  typedef struct packed {
    logic issue;  // a pair of table lookups enters the pipeline
    logic build;  // the pair belongs to a table build, not a query
  } rmst_req_t;

  // Pipeline occupancy seen by the controller.
  typedef struct packed {
    logic busy;   // any stage holds work
    logic res_v;  // a query result waits in the last stage
  } rmst_sts_t;

  function automatic logic [LOG_W-1:0] floor_log2(input logic [SPAN_W-1:0] v);
    logic [LOG_W-1:0] k;
    k = '0;
    for (int i = 1; i < SPAN_W; i++) begin
      if (v[i]) begin
        k = LOG_W'(i);
      end
    end
    return k;
  endfunction

endpackage

@@ rtl/range_max_sparse_table.sv @@
// Top level of the range-maximum-position engine: handshakes, control and
// result register. Depends on rmst_pkg and rmst_datapath.
//
//   channel   direction  handshake               payload
//   input     in         in_valid_i/in_ready_o   opcode, write_index, key_value,
//                                                range_left, range_right
//   result    out        out_valid_o/out_ready_i max_position, max_key, status
//   config    in         cfg_we_i                cfg_wdata_i (active_length)
//
// Writes, unused opcodes and rejected queries go straight to the result register;
// a valid query passes through the table reads at both block starts and then the
// two key reads. A build fills each level j >= 1 with 2^j <= n, for n = active_length
// clamped to 1..MAX_KEYS, one winner entry per cycle plus a pipeline drain per level.
// One item is in progress at a time; the next item is taken only while the
// output register is empty or its result leaves. Reset leaves no table built.
module range_max_sparse_table #(
  parameter int MAX_KEYS  = 1024,
  parameter int KEY_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rmst_pkg::LEN_W-1:0]          cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          opcode_i,
  input  logic [rmst_pkg::IDX_W-1:0]          write_index_i,
  input  logic signed [rmst_pkg::KEY_IO_W-1:0] key_value_i,
  input  logic [rmst_pkg::IDX_W-1:0]          range_left_i,
  input  logic [rmst_pkg::IDX_W-1:0]          range_right_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [rmst_pkg::IDX_W-1:0]          max_position_o,
  output logic signed [rmst_pkg::KEY_IO_W-1:0] max_key_o,
  output logic                                status_o
);
  import rmst_pkg::*;

  localparam int AW     = $clog2(MAX_KEYS);
  localparam int LEVELS = $clog2(MAX_KEYS + 1);
  localparam int LVW    = $clog2(LEVELS);
  localparam int CW     = $clog2(MAX_KEYS + 1);
  localparam int EW     = (CW > IDX_W) ? CW : IDX_W;
  localparam int XW     = (CW > LEN_W) ? CW : LEN_W;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_QISSUE = 5'b00010,
    S_QWAIT  = 5'b00100,
    S_BUILD  = 5'b01000,
    S_DRAIN  = 5'b10000
  } state_e;

  state_e                      state_q, state_d;
  logic [LEN_W-1:0]            act_len_q;
  logic [CW-1:0]               built_len_q, built_len_d;
  logic [CW-1:0]               n_q, n_d, bspan_q, bspan_d;
  logic [AW-1:0]               bi_q, bi_d;
  logic [LVW-1:0]              blvl_q, blvl_d;
  logic [IDX_W-1:0]            l_q, r_q;
  logic [LVW-1:0]              k_q;

  logic                        out_valid_q;
  logic [IDX_W-1:0]            out_pos_q;
  logic signed [KEY_IO_W-1:0]  out_key_q;
  logic                        out_status_q;

  logic                        accept, out_free, q_err, b_last, b_more;
  logic                        push_v, push_status;
  logic [IDX_W-1:0]            push_pos;
  logic signed [KEY_IO_W-1:0]  push_key;
  logic [SPAN_W-1:0]           span, q_ib;
  logic [XW-1:0]               al_x, n_clamp;

  rmst_req_t                   req;
  rmst_sts_t                   dp_sts;
  logic                        res_take, kw_en;
  logic [LVW-1:0]              rd_lvl, dst_lvl;
  logic [AW-1:0]               ia, ib, dst, dp_pos;
  logic signed [KEY_WIDTH-1:0] dp_key;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  assign q_err = (range_left_i > range_right_i) ||
                 (EW'(range_right_i) >= EW'(built_len_q));
  assign span  = SPAN_W'(range_right_i) - SPAN_W'(range_left_i) + SPAN_W'(1);
  assign q_ib  = SPAN_W'(r_q) + SPAN_W'(1) - (SPAN_W'(1) << k_q);

  assign al_x    = XW'(act_len_q);
  assign n_clamp = (al_x == '0) ? XW'(1) :
                   (al_x > XW'(MAX_KEYS)) ? XW'(MAX_KEYS) : al_x;

  assign b_last = (CW'(bi_q) + bspan_q) == n_q;
  assign b_more = {bspan_q, 1'b0} <= {1'b0, n_q};

  assign kw_en = accept && (opcode_e'(opcode_i) == OP_WRITE) &&
                 (EW'(write_index_i) < EW'(MAX_KEYS));

  // Lookup requests: a query reads level k at both block starts, a build
  // reads the level below at i and i + 2^(j-1).
  always_comb begin
    req.issue = 1'b0;
    req.build = 1'b0;
    rd_lvl    = k_q;
    ia        = AW'(l_q);
    ib        = AW'(q_ib);
    dst       = bi_q;
    dst_lvl   = blvl_q;
    if (state_q == S_QISSUE) begin
      req.issue = 1'b1;
    end else if (state_q == S_BUILD) begin
      req.issue = 1'b1;
      req.build = 1'b1;
      rd_lvl    = blvl_q - LVW'(1);
      ia        = bi_q;
      ib        = bi_q + AW'(bspan_q >> 1);
    end
  end

  assign res_take = (state_q == S_QWAIT) && dp_sts.res_v && out_free;

  always_comb begin
    state_d     = state_q;
    built_len_d = built_len_q;
    n_d         = n_q;
    bspan_d     = bspan_q;
    bi_d        = bi_q;
    blvl_d      = blvl_q;
    push_v      = 1'b0;
    push_pos    = '0;
    push_key    = '0;
    push_status = STATUS_OK;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (opcode_e'(opcode_i))
            OP_WRITE: begin
              push_v = 1'b1;
            end
            OP_BUILD: begin
              n_d     = CW'(n_clamp);
              bspan_d = CW'(1);
              blvl_d  = '0;
              state_d = S_DRAIN;
            end
            OP_QUERY: begin
              if (q_err) begin
                push_v      = 1'b1;
                push_status = STATUS_ERR;
              end else begin
                state_d = S_QISSUE;
              end
            end
            default: begin
              push_v      = 1'b1;
              push_status = STATUS_ERR;
            end
          endcase
        end
      end
      S_QISSUE: begin
        state_d = S_QWAIT;
      end
      S_QWAIT: begin
        if (res_take) begin
          push_v   = 1'b1;
          push_pos = IDX_W'(dp_pos);
          push_key = KEY_IO_W'(dp_key);
          state_d  = S_IDLE;
        end
      end
      S_BUILD: begin
        bi_d = bi_q + AW'(1);
        if (b_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The next level reads this one, so the pipeline empties first.
        if (!dp_sts.busy) begin
          if (b_more) begin
            blvl_d  = blvl_q + LVW'(1);
            bspan_d = {bspan_q[CW-2:0], 1'b0};
            bi_d    = '0;
            state_d = S_BUILD;
          end else if (out_free) begin
            built_len_d = n_q;
            push_v      = 1'b1;
            state_d     = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      act_len_q   <= LEN_W'(1);
      built_len_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      built_len_q <= built_len_d;
      if (cfg_we_i) begin
        act_len_q <= cfg_wdata_i;
      end
      if (push_v) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    bspan_q <= bspan_d;
    bi_q    <= bi_d;
    blvl_q  <= blvl_d;
    if (accept) begin
      l_q <= range_left_i;
      r_q <= range_right_i;
      k_q <= LVW'(floor_log2(span));
    end
    if (push_v) begin
      out_pos_q    <= push_pos;
      out_key_q    <= push_key;
      out_status_q <= push_status;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign max_position_o = out_pos_q;
  assign max_key_o      = out_key_q;
  assign status_o       = out_status_q;

  rmst_datapath #(
    .MAX_KEYS  (MAX_KEYS),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .kw_en_i    (kw_en),
    .kw_addr_i  (AW'(write_index_i)),
    .kw_data_i  (KEY_WIDTH'(key_value_i)),
    .req_i      (req),
    .rd_lvl_i   (rd_lvl),
    .ia_i       (ia),
    .ib_i       (ib),
    .dst_i      (dst),
    .dst_lvl_i  (dst_lvl),
    .res_take_i (res_take),
    .sts_o      (dp_sts),
    .res_pos_o  (dp_pos),
    .res_key_o  (dp_key)
  );

  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !dp_sts.busy)
    else $error("input taken while lookups are still in the pipeline");

  a_result_in_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_sts.res_v |-> (state_q == S_QWAIT))
    else $error("query result outside a query");

  a_build_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BUILD) |->
      (({1'b0, CW'(bi_q)} + {1'b0, bspan_q}) <= {1'b0, n_q}))
    else $error("build entry runs past the covered length");

  a_built_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) && !dp_sts.busy && !b_more && out_free |=>
      (built_len_q == $past(n_q)) && out_valid_q)
    else $error("build completion did not latch its length and result");

endmodule

@@ rtl/rmst_datapath.sv @@
// Key store, winner table and the lookup pipeline of the engine.
// Depends on rmst_pkg; instantiated by range_max_sparse_table.
module rmst_datapath #(
  parameter int  MAX_KEYS  = 1024,
  parameter int  KEY_WIDTH = 32,
  localparam int AW        = $clog2(MAX_KEYS),
  localparam int LEVELS    = $clog2(MAX_KEYS + 1),
  localparam int LVW       = $clog2(LEVELS)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        kw_en_i,
  input  logic [AW-1:0]               kw_addr_i,
  input  logic signed [KEY_WIDTH-1:0] kw_data_i,
  input  rmst_pkg::rmst_req_t         req_i,
  input  logic [LVW-1:0]              rd_lvl_i,
  input  logic [AW-1:0]               ia_i,
  input  logic [AW-1:0]               ib_i,
  input  logic [AW-1:0]               dst_i,
  input  logic [LVW-1:0]              dst_lvl_i,
  input  logic                        res_take_i,
  output rmst_pkg::rmst_sts_t         sts_o,
  output logic [AW-1:0]               res_pos_o,
  output logic signed [KEY_WIDTH-1:0] res_key_o
);
  import rmst_pkg::*;

  // Level 0 is never stored: its winner is the slot itself.
  localparam int TBL_DEPTH = (LEVELS - 1) * MAX_KEYS;
  localparam int TW        = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

  logic signed [KEY_WIDTH-1:0] key_mem [MAX_KEYS];
  logic [AW-1:0]               tbl_mem [TBL_DEPTH];

  logic [AW-1:0]               tda_q, tdb_q;
  logic signed [KEY_WIDTH-1:0] kda_q, kdb_q;

  logic                        sb_v_q, sc_v_q, sc_v_d;
  logic                        sb_bypass_q, sb_build_q, sc_build_q;
  logic [AW-1:0]               sb_ia_q, sb_ib_q, sb_dst_q, sc_dst_q;
  logic [AW-1:0]               sc_pa_q, sc_pb_q;
  logic [LVW-1:0]              sb_lvl_q, sc_lvl_q;

  logic                        bypass;
  logic [LVW-1:0]              rd_lvl_m1, wr_lvl_m1;
  logic [TW-1:0]               ta, tb, tw_addr;
  logic [AW-1:0]               pa, pb, win_build;

  assign bypass    = (rd_lvl_i == '0);
  assign rd_lvl_m1 = rd_lvl_i - LVW'(1);
  assign wr_lvl_m1 = sc_lvl_q - LVW'(1);
  assign ta        = TW'(rd_lvl_m1) * TW'(MAX_KEYS) + TW'(ia_i);
  assign tb        = TW'(rd_lvl_m1) * TW'(MAX_KEYS) + TW'(ib_i);
  assign tw_addr   = TW'(wr_lvl_m1) * TW'(MAX_KEYS) + TW'(sc_dst_q);

  assign pa = sb_bypass_q ? sb_ia_q : tda_q;
  assign pb = sb_bypass_q ? sb_ib_q : tdb_q;

  // A build keeps the left winner only on a strict win; a query hands ties
  // to the first block.
  assign win_build = (kda_q > kdb_q) ? sc_pa_q : sc_pb_q;
  assign res_pos_o = (kdb_q > kda_q) ? sc_pb_q : sc_pa_q;
  assign res_key_o = (kdb_q > kda_q) ? kdb_q : kda_q;

  assign sts_o.busy  = sb_v_q | sc_v_q;
  assign sts_o.res_v = sc_v_q & ~sc_build_q;

  // A query result stays in the last stage until the output register frees.
  assign sc_v_d = sb_v_q | (sc_v_q & ~sc_build_q & ~res_take_i);

  always_ff @(posedge clk_i) begin
    if (kw_en_i) begin
      key_mem[kw_addr_i] <= kw_data_i;
    end
    if (req_i.issue && !bypass) begin
      tda_q <= tbl_mem[ta];
      tdb_q <= tbl_mem[tb];
    end
    if (sb_v_q) begin
      kda_q <= key_mem[pa];
      kdb_q <= key_mem[pb];
    end
    if (sc_v_q && sc_build_q) begin
      tbl_mem[tw_addr] <= win_build;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.issue) begin
      sb_bypass_q <= bypass;
      sb_build_q  <= req_i.build;
      sb_ia_q     <= ia_i;
      sb_ib_q     <= ib_i;
      sb_dst_q    <= dst_i;
      sb_lvl_q    <= dst_lvl_i;
    end
    if (sb_v_q) begin
      sc_pa_q    <= pa;
      sc_pb_q    <= pb;
      sc_dst_q   <= sb_dst_q;
      sc_lvl_q   <= sb_lvl_q;
      sc_build_q <= sb_build_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_v_q <= 1'b0;
      sc_v_q <= 1'b0;
    end else begin
      sb_v_q <= req_i.issue;
      sc_v_q <= sc_v_d;
    end
  end

endmodule

@@ sim/rmst_result_check.sv @@
// Result checker for range_max_sparse_table: follows the input, result and
// register transfers, keeps its own key store and winner table, and compares.
// Depends on rmst_pkg for widths, opcodes and status codes.
module rmst_result_check (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [rmst_pkg::LEN_W-1:0]           cfg_wdata_i,
  input  logic                                 in_valid_i,
  input  logic                                 in_ready_i,
  input  logic [1:0]                           opcode_i,
  input  logic [rmst_pkg::IDX_W-1:0]           write_index_i,
  input  logic signed [rmst_pkg::KEY_IO_W-1:0] key_value_i,
  input  logic [rmst_pkg::IDX_W-1:0]           range_left_i,
  input  logic [rmst_pkg::IDX_W-1:0]           range_right_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_ready_i,
  input  logic [rmst_pkg::IDX_W-1:0]           max_position_i,
  input  logic signed [rmst_pkg::KEY_IO_W-1:0] max_key_i,
  input  logic                                 status_i,
  output int                                   fail_count_o,
  output int                                   pending_count_o,
  output int                                   checked_count_o
);
  import rmst_pkg::*;

  localparam int NKEYS   = 1024;
  localparam int NLEVELS = 11;

  typedef struct packed {
    logic [IDX_W-1:0]           pos;
    logic signed [KEY_IO_W-1:0] key;
    logic                       status;
  } rmq_result_t;

  logic signed [KEY_IO_W-1:0] key_mem [NKEYS];
  logic [IDX_W-1:0]           winner_pos [NLEVELS][NKEYS];
  int unsigned                built_len = 0;
  logic [LEN_W-1:0]           cfg_len = LEN_W'(1);
  rmq_result_t                expected_q [$];
  int                         n_fail = 0;
  int                         n_checked = 0;

  // Fills every level of the winner table that fits within the length latched now.
  function automatic void build_winners();
    int unsigned n;
    int unsigned half;
    int unsigned a;
    int unsigned b;
    n = cfg_len;
    if (n == 0) begin
      n = 1;
    end
    if (n > NKEYS) begin
      n = NKEYS;
    end
    for (int unsigned i = 0; i < n; i++) begin
      winner_pos[0][i] = IDX_W'(i);
    end
    for (int unsigned j = 1; (1 << j) <= n; j++) begin
      half = 1 << (j - 1);
      for (int unsigned i = 0; i + (1 << j) <= n; i++) begin
        a = winner_pos[j-1][i];
        b = winner_pos[j-1][i+half];
        winner_pos[j][i] = (key_mem[a] > key_mem[b]) ? IDX_W'(a) : IDX_W'(b);
      end
    end
    built_len = n;
  endfunction

  // Applies one item to the model state and returns the result it should give.
  function automatic rmq_result_t apply_item(input logic [1:0] op,
                                             input logic [IDX_W-1:0] idx,
                                             input logic signed [KEY_IO_W-1:0] kv,
                                             input logic [IDX_W-1:0] lo,
                                             input logic [IDX_W-1:0] hi);
    rmq_result_t res;
    int unsigned span;
    int unsigned lvl;
    int unsigned a;
    int unsigned b;
    int unsigned w;
    res = '0;
    res.status = STATUS_OK;
    case (op)
      OP_WRITE: begin
        key_mem[idx] = kv;
      end
      OP_BUILD: begin
        build_winners();
      end
      OP_QUERY: begin
        if (lo > hi || hi >= built_len) begin
          res.status = STATUS_ERR;
        end else begin
          span = hi - lo + 1;
          lvl = 0;
          while ((2 << lvl) <= span) begin
            lvl++;
          end
          a = winner_pos[lvl][lo];
          b = winner_pos[lvl][hi - (1 << lvl) + 1];
          // Ties go to the block that starts at the left end.
          w = (key_mem[a] < key_mem[b]) ? b : a;
          res.pos = IDX_W'(w);
          res.key = key_mem[w];
        end
      end
      default: begin
        res.status = STATUS_ERR;
      end
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rmq_result_t exp_res;
    if (!rst_ni) begin
      built_len = 0;
      cfg_len = LEN_W'(1);
      expected_q.delete();
      n_fail = 0;
      n_checked = 0;
      fail_count_o <= 0;
      pending_count_o <= 0;
      checked_count_o <= 0;
    end else begin
      // The result side is handled first, so that a transfer arriving with no
      // expectation waiting is not hidden by an input taken at the same edge.
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10) begin
            $display("rmst_result_check: unexpected result pos %0d key %0d status %0b",
                     max_position_i, max_key_i, status_i);
          end
        end else begin
          exp_res = expected_q.pop_front();
          n_checked++;
          if (exp_res.pos !== max_position_i || exp_res.key !== max_key_i ||
              exp_res.status !== status_i) begin
            n_fail++;
            if (n_fail <= 10) begin
              $display("rmst_result_check: result %0d mismatch: expected pos %0d ",
                       n_checked, exp_res.pos,
                       "key %0d status %0b, got pos %0d key %0d status %0b",
                       exp_res.key, exp_res.status,
                       max_position_i, max_key_i, status_i);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_q.push_back(apply_item(opcode_i, write_index_i, key_value_i,
                                        range_left_i, range_right_i));
      end
      if (cfg_we_i) begin
        cfg_len = cfg_wdata_i;
      end
      fail_count_o <= n_fail;
      pending_count_o <= expected_q.size();
      checked_count_o <= n_checked;
    end
  end

endmodule

@@ sim/tb_top.sv @@
// Testbench top for range_max_sparse_table: clock, reset, stimulus and verdict.
// Depends on rmst_pkg, the block itself and rmst_result_check.
module tb_top;
  import rmst_pkg::*;

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam int         NKEYS      = 1024;
  localparam int         CLK_PERIOD = 12;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [LEN_W-1:0]           cfg_wdata_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic [1:0]                 opcode_i = OP_WRITE;
  logic [IDX_W-1:0]           write_index_i = '0;
  logic signed [KEY_IO_W-1:0] key_value_i = '0;
  logic [IDX_W-1:0]           range_left_i = '0;
  logic [IDX_W-1:0]           range_right_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic [IDX_W-1:0]           max_position_o;
  logic signed [KEY_IO_W-1:0] max_key_o;
  logic                       status_o;

  int fail_count;
  int pending_results;
  int checked_results;

  int          send_idle_pct = 0;
  int          stall_pct = 0;
  bit          key_known [NKEYS];
  int unsigned cfg_n = 1;
  int unsigned built_n = 0;
  int          n_items = 0;
  int          n_builds = 0;
  int          n_queries = 0;

  // Keys for the directed part: extremes and repeated maxima for tie-breaking.
  logic [31:0] tie_keys [8] = '{32'h8000_0000, 32'd5, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'd5};

  range_max_sparse_table dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .write_index_i  (write_index_i),
    .key_value_i    (key_value_i),
    .range_left_i   (range_left_i),
    .range_right_i  (range_right_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .max_position_o (max_position_o),
    .max_key_o      (max_key_o),
    .status_o       (status_o)
  );

  rmst_result_check result_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .opcode_i        (opcode_i),
    .write_index_i   (write_index_i),
    .key_value_i     (key_value_i),
    .range_left_i    (range_left_i),
    .range_right_i   (range_right_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .max_position_i  (max_position_o),
    .max_key_i       (max_key_o),
    .status_i        (status_o),
    .fail_count_o    (fail_count),
    .pending_count_o (pending_results),
    .checked_count_o (checked_results)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #(CLK_PERIOD * 2_000_000);
    $display("tb_top: done, errors");
    $finish;
  end

  function automatic logic [31:0] pick_key();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      // A narrow spread of values makes equal keys, and so ties, common.
      2, 3, 4: return 32'(int'($urandom_range(6)) - 3);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] pick_slot();
    if ($urandom_range(3) == 0) begin
      return IDX_W'($urandom_range(NKEYS - 1));
    end
    return IDX_W'($urandom_range(cfg_n - 1));
  endfunction

  // Presents one item and returns at the edge of its transfer, valid left high.
  task automatic send_item(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [31:0] kv, input logic [IDX_W-1:0] lo,
                           input logic [IDX_W-1:0] hi);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    write_index_i <= idx;
    key_value_i <= kv;
    range_left_i <= lo;
    range_right_i <= hi;
    do @(posedge clk_i); while (!in_ready_o);
    n_items++;
    case (op)
      OP_WRITE: key_known[idx] = 1'b1;
      OP_BUILD: begin
        built_n = cfg_n;
        n_builds++;
      end
      OP_QUERY: n_queries++;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
  endtask

  task automatic set_length(input logic [LEN_W-1:0] len);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_n = (len == 0) ? 1 : ((len > NKEYS) ? NKEYS : len);
  endtask

  // Every slot that the build will read is written first.
  task automatic run_build();
    for (int unsigned i = 0; i < cfg_n; i++) begin
      if (!key_known[i]) begin
        send_item(OP_WRITE, IDX_W'(i), pick_key(), IDX_W'($urandom), IDX_W'($urandom));
      end
    end
    send_item(OP_BUILD, IDX_W'($urandom), $urandom, IDX_W'($urandom), IDX_W'($urandom));
  endtask

  task automatic send_query(input bit in_bounds);
    int unsigned lo;
    int unsigned hi;
    int unsigned span;
    int unsigned top_lvl;
    if (in_bounds && built_n > 0) begin
      case ($urandom_range(3))
        0: begin
          hi = $urandom_range(built_n - 1);
          lo = hi;
        end
        1: begin
          lo = 0;
          hi = built_n - 1;
        end
        2: begin
          top_lvl = 0;
          while ((2 << top_lvl) <= built_n) begin
            top_lvl++;
          end
          span = 1 << $urandom_range(top_lvl);
          lo = $urandom_range(built_n - span);
          hi = lo + span - 1;
        end
        default: begin
          hi = $urandom_range(built_n - 1);
          lo = $urandom_range(hi);
        end
      endcase
    end else if (built_n < NKEYS && $urandom_range(1) == 1) begin
      hi = $urandom_range(NKEYS - 1, built_n);
      lo = $urandom_range(hi);
    end else begin
      hi = $urandom_range(NKEYS - 2);
      lo = $urandom_range(NKEYS - 1, hi + 1);
    end
    send_item(OP_QUERY, IDX_W'($urandom), $urandom, IDX_W'(lo), IDX_W'(hi));
  endtask

  initial begin
    int          budget;
    int          done_items;
    int          seq;
    int          roll;
    logic [LEN_W-1:0] len_pick;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: a query before any build, the unused opcode, the length
    // register at its reset value, at zero and at eight with tied maxima.
    send_item(OP_QUERY, '0, '0, '0, '0);
    send_item(OP_UNUSED, '1, 32'hFFFF_FFFF, '1, '1);
    send_item(OP_WRITE, '0, 32'h8000_0000, '0, '0);
    send_item(OP_BUILD, '0, '0, '0, '0);
    send_item(OP_QUERY, '0, '0, 10'd0, 10'd0);
    send_item(OP_QUERY, '0, '0, 10'd0, 10'd1);
    send_item(OP_QUERY, '0, '0, 10'd1, 10'd0);
    send_item(OP_QUERY, '0, '0, 10'd1023, 10'd1023);
    set_length(LEN_W'(0));
    send_item(OP_BUILD, '1, 32'hFFFF_FFFF, '1, '1);
    send_item(OP_QUERY, '0, '0, 10'd0, 10'd0);
    set_length(LEN_W'(8));
    for (int i = 1; i < 8; i++) begin
      send_item(OP_WRITE, IDX_W'(i), tie_keys[i], '0, '0);
    end
    send_item(OP_WRITE, 10'd1023, 32'h7FFF_FFFF, '0, '0);
    send_item(OP_BUILD, '0, '0, '0, '0);
    send_item(OP_QUERY, '0, '0, 10'd0, 10'd7);
    send_item(OP_QUERY, '0, '0, 10'd2, 10'd5);
    send_item(OP_QUERY, '0, '0, 10'd3, 10'd5);
    send_item(OP_QUERY, '0, '0, 10'd6, 10'd7);
    send_item(OP_QUERY, '0, '0, 10'd0, 10'd1023);

    // Random part: each phase sets a length, then runs sequences of a few
    // writes, a build and a burst of queries with some noise mixed in. The
    // first full-length build already fills every key slot.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 48; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 48; end
        default: begin send_idle_pct = 19; stall_pct = 19; end
      endcase
      case (phase)
        0: len_pick = LEN_W'(1024);
        1: len_pick = LEN_W'(2047);
        2: len_pick = LEN_W'($urandom_range(16, 2));
        3: len_pick = LEN_W'($urandom_range(64, 17));
        4: len_pick = LEN_W'($urandom_range(300, 65));
        5: len_pick = LEN_W'($urandom_range(8, 1));
        default: len_pick = LEN_W'($urandom_range(64, 2));
      endcase
      set_length(len_pick);
      budget = 8;
      done_items = 0;
      seq = 0;
      while (done_items < budget) begin
        repeat ($urandom_range(4)) begin
          send_item(OP_WRITE, pick_slot(), pick_key(), IDX_W'($urandom), IDX_W'($urandom));
          done_items++;
        end
        run_build();
        done_items++;
        // Once per phase the sender holds off until the build has come back.
        if (seq == 0) begin
          wait_drained();
        end
        repeat ($urandom_range(16, 4)) begin
          roll = $urandom_range(99);
          if (roll < 70) begin
            send_query(1'b1);
          end else if (roll < 82) begin
            send_query(1'b0);
          end else if (roll < 94) begin
            // Keys are read live, so a write after the build can move the result.
            send_item(OP_WRITE, pick_slot(), pick_key(), IDX_W'($urandom), IDX_W'($urandom));
          end else begin
            send_item(OP_UNUSED, IDX_W'($urandom), $urandom, IDX_W'($urandom),
                      IDX_W'($urandom));
          end
          done_items++;
        end
        seq++;
      end
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("tb_top: %0d items sent, %0d of them queries and %0d builds, over lengths 1 to 1024",
             n_items, n_queries, n_builds);
    $display("tb_top: %0d results checked, %0d failures, %0d results still awaited",
             checked_results, fail_count, pending_results);
    if (fail_count == 0 && pending_results == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

@@ range_max_sparse_table.f @@
rtl/rmst_pkg.sv
rtl/rmst_datapath.sv
rtl/range_max_sparse_table.sv
sim/rmst_result_check.sv
sim/tb_top.sv
